### hdl/sts_pkg.sv
// Shared types and constants for the sorted table search block.
`default_nettype none

package sts_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 7;

  localparam logic ReqAdd    = 1'b0;
  localparam logic ReqSearch = 1'b1;

  localparam logic [1:0] StatAdded    = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatFound    = 2'd2;
  localparam logic [1:0] StatNotFound = 2'd3;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StProbe = 2'b10
  } state_e;

  // data handed from one cell to the next
  typedef struct packed {
    logic signed [DataW-1:0] entry;
    logic                    gt;
  } link_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic in_use;
    logic at_end;
    logic ins_en;
    logic cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/sts_cell.sv
// One table cell: holds an entry, shifts on sorted insert, compares against a key.
`default_nettype none

module sts_cell
  import sts_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire cell_ctl_t               ctl_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire link_t                   prev_i,
  output link_t                        next_o,
  output logic                         eq_o,
  output logic                         lt_o
);

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    eq_q, eq_d;
  logic                    lt_q, lt_d;
  logic                    gt;

  assign gt = ctl_i.in_use && (entry_q > value_i);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en && (gt || ctl_i.at_end)) begin
      entry_d = prev_i.gt ? prev_i.entry : value_i;
    end
    eq_d = eq_q;
    lt_d = lt_q;
    if (ctl_i.cmp_en) begin
      eq_d = (entry_q == value_i);
      lt_d = (entry_q < value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    eq_q    <= eq_d;
    lt_q    <= lt_d;
  end

  assign next_o.entry = entry_q;
  assign next_o.gt    = gt;
  assign eq_o         = eq_q;
  assign lt_o         = lt_q;

endmodule

`default_nettype wire

### hdl/sorted_table_binary_search.sv
// Top level: sorted table as a row of cells with a binary search sequencer.
//
//   channel   ports                                  transfer
//   request   start_i busy_o req_type_i value_i      start_i high, busy_o low
//   result    done_o status_o position_o             done_o high, one cycle
//
// An add is taken at the transfer: cells above the insert point shift, the
// insert cell loads, and the result strobes on the next cycle; busy_o stays low.
// A search compares the key in all cells at the transfer, then probes the
// registered flags once a cycle, stopping on a match or an empty range. The
// result strobes in the first cycle with busy_o low again.
// Reset empties the table at once. Results cannot be stalled.
`default_nettype none

module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    req_type_i,
  input  wire logic signed [DataW-1:0] value_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [PosW-1:0]              position_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW   = CntW + 1;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic signed [SW-1:0]   left_q, left_d, right_q, right_d;
  logic                   done_q, done_d;
  logic [1:0]             status_q, status_d;
  logic [PosW-1:0]        pos_q, pos_d;

  logic                   accept, do_add, do_search;
  logic signed [SW-1:0]   mid;
  logic [IdxW-1:0]        mid_idx;
  logic [DEPTH-1:0]       eq_vec, lt_vec;
  link_t                  links [DEPTH+1];

  assign accept    = start_i && (state_q == StIdle);
  assign do_add    = accept && (req_type_i == ReqAdd) && (count_q < CntW'(DEPTH));
  assign do_search = accept && (req_type_i == ReqSearch);

  assign links[0] = '{entry: '0, gt: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.in_use = (CntW'(i) < count_q);
    assign ctl.at_end = (CntW'(i) == count_q);
    assign ctl.ins_en = do_add;
    assign ctl.cmp_en = do_search;

    sts_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (value_i),
      .prev_i  (links[i]),
      .next_o  (links[i+1]),
      .eq_o    (eq_vec[i]),
      .lt_o    (lt_vec[i])
    );
  end

  assign mid     = left_q + ((right_q - left_q) >>> 1);
  assign mid_idx = IdxW'($unsigned(mid));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    left_d   = left_q;
    right_d  = right_q;
    done_d   = 1'b0;
    status_d = status_q;
    pos_d    = pos_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == ReqAdd) begin
            done_d = 1'b1;
            pos_d  = '0;
            if (do_add) begin
              count_d  = count_q + CntW'(1);
              status_d = StatAdded;
            end else begin
              status_d = StatFull;
            end
          end else begin
            left_d  = '0;
            right_d = $signed({1'b0, count_q}) - SW'(1);
            state_d = StProbe;
          end
        end
      end
      StProbe: begin
        if (left_q > right_q) begin
          done_d   = 1'b1;
          status_d = StatNotFound;
          pos_d    = '0;
          state_d  = StIdle;
        end else if (eq_vec[mid_idx]) begin
          done_d   = 1'b1;
          status_d = StatFound;
          pos_d    = PosW'($unsigned(mid));
          state_d  = StIdle;
        end else if (lt_vec[mid_idx]) begin
          left_d = mid + SW'(1);
        end else begin
          right_d = mid - SW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    right_q  <= right_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign position_o = pos_q;

endmodule

`default_nettype wire

### tb/sv/sorted_table_binary_search_test.sv
// Self-checking testbench for the sorted table with insert and binary search.
module sorted_table_binary_search_test
  import sts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = 128;
  localparam int unsigned RandomItems = 730;
  localparam int unsigned IdlePct     = 11;
  localparam int unsigned AddPct      = 30;

  typedef logic signed [DataW-1:0] word_t;

  localparam word_t MaxVal = 32'sh7fffffff;
  localparam word_t MinVal = 32'sh80000000;
  localparam word_t NegOne = 32'shffffffff;

  typedef struct packed {
    logic            req;
    word_t           value;
    logic            typed;
    logic [1:0]      status;
    logic [PosW-1:0] pos;
  } directed_row_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] pos;
  } answer_t;

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            start_i    = 1'b0;
  logic            req_type_i = ReqAdd;
  word_t           value_i    = '0;
  logic            busy_o;
  logic            done_o;
  logic [1:0]      status_o;
  logic [PosW-1:0] position_o;

  // typed-in expectation travelling with the transfer
  logic            typed_q      = 1'b0;
  logic [1:0]      typed_status = StatAdded;
  logic [PosW-1:0] typed_pos    = '0;

  word_t   sorted_vals [Depth];
  int      stored_count = 0;
  answer_t expected_q [$];
  word_t   added_vals [$];
  int      errors = 0;
  bit      quiet = 1'b0;

  directed_row_t directed_rows [24] = '{
    '{ReqSearch, 32'sd0,          1'b1, StatNotFound, 7'd0},
    '{ReqSearch, MinVal,          1'b1, StatNotFound, 7'd0},
    '{ReqSearch, MaxVal,          1'b1, StatNotFound, 7'd0},
    '{ReqAdd,    MaxVal,          1'b1, StatAdded,    7'd0},
    '{ReqSearch, MaxVal,          1'b1, StatFound,    7'd0},
    '{ReqSearch, MinVal,          1'b1, StatNotFound, 7'd0},
    '{ReqAdd,    MinVal,          1'b1, StatAdded,    7'd0},
    '{ReqAdd,    32'sd0,          1'b1, StatAdded,    7'd0},
    '{ReqAdd,    NegOne,          1'b1, StatAdded,    7'd0},
    '{ReqAdd,    32'sd0,          1'b1, StatAdded,    7'd0},
    '{ReqAdd,    32'sd0,          1'b1, StatAdded,    7'd0},
    '{ReqSearch, 32'sd0,          1'b0, StatAdded,    7'd0},
    '{ReqSearch, NegOne,          1'b0, StatAdded,    7'd0},
    '{ReqSearch, MinVal,          1'b0, StatAdded,    7'd0},
    '{ReqSearch, MaxVal,          1'b0, StatAdded,    7'd0},
    '{ReqSearch, 32'sd1,          1'b0, StatAdded,    7'd0},
    '{ReqSearch, 32'sh7ffffffe,   1'b0, StatAdded,    7'd0},
    '{ReqAdd,    32'sh55555555,   1'b1, StatAdded,    7'd0},
    '{ReqAdd,    32'shaaaaaaaa,   1'b1, StatAdded,    7'd0},
    '{ReqSearch, 32'sh55555555,   1'b0, StatAdded,    7'd0},
    '{ReqSearch, 32'shaaaaaaaa,   1'b0, StatAdded,    7'd0},
    '{ReqSearch, 32'shfffffffe,   1'b0, StatAdded,    7'd0},
    '{ReqAdd,    32'sd1,          1'b1, StatAdded,    7'd0},
    '{ReqSearch, 32'sd1,          1'b0, StatAdded,    7'd0}
  };

  sorted_table_binary_search #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_type_i(req_type_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .position_o(position_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ordered insert on add, midpoint probe search on lookup
  function automatic answer_t insert_or_lookup(logic req, word_t v);
    answer_t res;
    int      p;
    int      lo;
    int      hi;
    int      mid;
    res.status = StatNotFound;
    res.pos    = '0;
    if (req == ReqAdd) begin
      if (stored_count < Depth) begin
        p = stored_count;
        while (p > 0 && sorted_vals[p-1] > v) begin
          sorted_vals[p] = sorted_vals[p-1];
          p--;
        end
        sorted_vals[p] = v;
        stored_count++;
        res.status = StatAdded;
      end else begin
        res.status = StatFull;
      end
    end else begin
      lo = 0;
      hi = stored_count - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (sorted_vals[mid] == v) begin
          res.status = StatFound;
          res.pos    = mid[PosW-1:0];
          break;
        end
        if (sorted_vals[mid] < v) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.status = status_o;
        got.pos    = position_o;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d position %0d",
                   $time, got.status, got.pos);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
          if (got.pos !== want.pos) begin
            errors++;
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.pos, got.pos);
          end
        end
      end
      if (start_i && !busy_o) begin
        want = insert_or_lookup(req_type_i, value_i);
        if (typed_q) begin
          want.status = typed_status;
          want.pos    = typed_pos;
        end
        expected_q.push_back(want);
      end
    end
  end

  task automatic send(input logic req, input word_t v, input logic typed,
                      input logic [1:0] status, input logic [PosW-1:0] pos);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i      <= 1'b1;
    req_type_i   <= req;
    value_i      <= v;
    typed_q      <= typed;
    typed_status <= status;
    typed_pos    <= pos;
    if (req == ReqAdd && added_vals.size() < Depth) added_vals.push_back(v);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    logic        req;
    word_t       v;
    int unsigned pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send(directed_rows[i].req, directed_rows[i].value, directed_rows[i].typed,
           directed_rows[i].status, directed_rows[i].pos);
    end

    for (int i = 0; i < RandomItems; i++) begin
      quiet = (i >= 300 && i < 450);
      req   = ($urandom_range(0, 99) < AddPct) ? ReqAdd : ReqSearch;
      pick  = $urandom_range(0, 9);
      if (added_vals.size() != 0 && pick < ((req == ReqSearch) ? 6 : 2)) begin
        v = added_vals[$urandom_range(0, added_vals.size() - 1)];
        case (pick % 3)
          1: v = v + 1;
          2: v = v - 1;
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0, 1: v = $urandom;
          2: v = $signed($urandom_range(0, 40)) - 20;
          default: begin
            case ($urandom_range(0, 3))
              0: v = MaxVal;
              1: v = MinVal;
              2: v = '0;
              default: v = NegOne;
            endcase
          end
        endcase
      end
      send(req, v, 1'b0, StatAdded, '0);
    end

    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/sts_pkg.sv
hdl/sts_cell.sv
hdl/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_test.sv
